// ===== design/complex_vector_reduction_assert.svh =====
// Assertion macros for the complex vector reduction block.
`ifndef COMPLEX_VECTOR_REDUCTION_ASSERT_SVH
`define COMPLEX_VECTOR_REDUCTION_ASSERT_SVH
// Implication checked on every clock edge outside reset.
`define CVR_ASSERT_IMPL(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed");
// Next-cycle implication checked outside reset.
`define CVR_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed");
`endif

// ===== design/cvr_pkg.sv =====
// Shared types and constants for the complex vector reduction block.
package cvr_pkg;
   localparam logic [2:0] MODE_RDOT = 3'd0;
   localparam logic [2:0] MODE_CDOT = 3'd1;
   localparam logic [2:0] MODE_MAXM = 3'd2;
   localparam logic [2:0] MODE_SUMM = 3'd3;
   localparam logic [2:0] MODE_WSQ  = 3'd4;
   localparam logic [2:0] MODE_MINQ = 3'd5;
   localparam logic signed [63:0] S64_MAX = 64'sh7FFF_FFFF_FFFF_FFFF;
   localparam logic signed [63:0] S64_MIN = 64'sh8000_0000_0000_0000;

   typedef enum logic [3:0] {
      ST_IDLE, ST_MUL, ST_SQRT, ST_DIV, ST_WSQ, ST_FOLD, ST_OUT
   } state_type;

   // Iteration unit operation selects.
   typedef enum logic [1:0] {
      OP_NONE, OP_SQRT, OP_DIV
   } op_type;

   typedef struct packed {
      logic    start;
      op_type  op;
   } iter_ctl_type;

   typedef struct packed {
      logic busy;
      logic done;
   } iter_sts_type;

   // Saturating signed 64-bit add.
   function automatic logic signed [63:0] sat_add(input logic signed [63:0] a,
                                                   input logic signed [63:0] b);
      logic signed [63:0] s;
      s = a + b;
      if (!a[63] && !b[63] && s[63]) return S64_MAX;
      if (a[63] && b[63] && !s[63]) return S64_MIN;
      return s;
   endfunction
endpackage

// ===== design/cvr_iter.sv =====
// Shared iterative unit: restoring square root and signed division, one bit per cycle.
module cvr_iter (
   input  logic                  clock,
   input  logic                  reset,
   input  cvr_pkg::iter_ctl_type ctl,
   input  logic [63:0]           sqrt_arg,
   input  logic signed [31:0]    num,
   input  logic signed [31:0]    den,
   output cvr_pkg::iter_sts_type sts,
   output logic [63:0]           res
);
   import cvr_pkg::*;

   logic [63:0] rem_ff, rem_in;
   logic [63:0] acc_ff, acc_in;
   logic [63:0] val_ff, val_in;
   logic [5:0]  cnt_ff, cnt_in;
   op_type      op_ff, op_in;
   logic        busy_ff, busy_in, done_ff, done_in;
   logic        neg_ff, neg_in;
   logic [32:0] dabs_ff, dabs_in;
   logic [65:0] trial;
   logic [64:0] dtrial;

   // One step of the selected recurrence.
   always_comb begin
      rem_in = rem_ff; acc_in = acc_ff; val_in = val_ff; cnt_in = cnt_ff;
      op_in = op_ff; busy_in = busy_ff; done_in = 1'b0; neg_in = neg_ff;
      dabs_in = dabs_ff;
      trial = '0; dtrial = '0;
      if (ctl.start) begin
         busy_in = 1'b1; op_in = ctl.op; cnt_in = '0;
         rem_in = '0; acc_in = '0;
         if (ctl.op == OP_DIV) begin
            // |num| << 16 as a 48-bit dividend, shifted out from the top.
            val_in = {16'd0, (num[31] ? 32'(-num) : 32'(num)), 16'd0};
            val_in[47:16] = num[31] ? (~num + 32'd1) : num;
            dabs_in = den[31] ? (33'd0 - {den[31], den}) : {1'b0, den};
            neg_in = num[31] ^ den[31];
         end else begin
            val_in = sqrt_arg;
         end
      end else if (busy_ff) begin
         if (op_ff == OP_SQRT) begin
            trial = {rem_ff, val_ff[63:62]} - {acc_ff, 2'b01};
            if (!trial[65]) begin
               rem_in = trial[63:0];
               acc_in = {acc_ff[62:0], 1'b1};
            end else begin
               rem_in = {rem_ff[61:0], val_ff[63:62]};
               acc_in = {acc_ff[62:0], 1'b0};
            end
            val_in = {val_ff[61:0], 2'b00};
            cnt_in = cnt_ff + 6'd1;
            if (cnt_ff == 6'd31) begin busy_in = 1'b0; done_in = 1'b1; end
         end else begin
            dtrial = {rem_ff[63:0], val_ff[47]} - {32'd0, dabs_ff};
            if (!dtrial[64]) begin
               rem_in = dtrial[63:0];
               acc_in = {acc_ff[62:0], 1'b1};
            end else begin
               rem_in = {rem_ff[62:0], val_ff[47]};
               acc_in = {acc_ff[62:0], 1'b0};
            end
            val_in = {val_ff[62:0], 1'b0};
            cnt_in = cnt_ff + 6'd1;
            if (cnt_ff == 6'd47) begin
               busy_in = 1'b0; done_in = 1'b1;
               if (neg_ff) acc_in = 64'd0 - acc_in;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0; done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in; done_ff <= done_in;
      end
      rem_ff <= rem_in; acc_ff <= acc_in; val_ff <= val_in; cnt_ff <= cnt_in;
      op_ff <= op_in; neg_ff <= neg_in; dabs_ff <= dabs_in;
   end

   assign sts.busy = busy_ff;
   assign sts.done = done_ff;
   assign res = acc_ff;
endmodule

// ===== design/complex_vector_reduction.sv =====
// Top level of the complex vector reduction block.
// Complex vector reduction: each request transaction carries one element pair
// and is folded by the mode in the reduce_mode register; the element marked
// last produces one response transaction and clears the accumulators. After
// the idle state accepts a request transaction and the multiply state forms
// the products, the dot modes (and the quotient mode when the denominator is
// zero) fold the element directly, weighted squares sums four 32x32 partial
// products, the modulus modes run 32 square-root steps of the shared iteration
// unit and the quotient mode 48 division steps of the same unit. The last
// element of a vector also passes through a state that loads the response
// register. A pending response does not block new elements; only a second
// finished vector waits for the response register to be taken. req_tready and
// csr_ready are high while the sequencer is idle.
module complex_vector_reduction (
   input  logic         clock,
   input  logic         reset,
   input  logic         csr_valid,
   output logic         csr_ready,
   input  logic [2:0]   csr_data,     // reduce_mode
   input  logic         req_tvalid,
   output logic         req_tready,
   input  logic [127:0] req_tdata,    // x_re, x_im, y_re, y_im
   input  logic         req_tlast,    // last_elem
   output logic         rsp_tvalid,
   input  logic         rsp_tready,
   output logic [127:0] rsp_tdata,    // result_re, result_im
   output logic         rsp_tuser     // none_found
);
   import cvr_pkg::*;
   `include "complex_vector_reduction_assert.svh"

   state_type state_ff, state_in;
   logic [2:0] mode_ff;
   logic signed [31:0] xr_ff, xi_ff, yr_ff, yi_ff;
   logic last_ff;
   logic signed [63:0] acc_re_ff, acc_re_in, acc_im_ff, acc_im_in;
   logic found_ff, found_in;
   logic signed [63:0] p0_ff, p1_ff, p2_ff, p3_ff;
   logic [63:0] mag2_ff, mag2_in, ysq_ff;
   logic [1:0] wcnt_ff;
   logic [127:0] wacc_ff;
   logic [31:0] wa_half, wb_half;
   logic [63:0] wpp;
   logic [127:0] wsh;
   logic [63:0] wterm;
   logic rsp_v_ff;
   logic [127:0] rsp_d_ff;
   logic rsp_u_ff;
   iter_ctl_type ictl;
   iter_sts_type ists;
   logic [63:0] ires;
   logic take;
   logic out_load;

   assign req_tready = (state_ff == ST_IDLE);
   assign take = req_tvalid && req_tready;
   assign csr_ready = (state_ff == ST_IDLE);
   assign out_load = (state_ff == ST_OUT) && (!rsp_v_ff || rsp_tready);

   // Squared modulus of x, available while the iteration unit is started.
   assign mag2_in = 64'(64'(xr_ff) * 64'(xr_ff)) + 64'(64'(xi_ff) * 64'(xi_ff));

   cvr_iter u_iter (.clock(clock), .reset(reset), .ctl(ictl), .sqrt_arg(mag2_in),
                    .num(xr_ff), .den(yr_ff), .sts(ists), .res(ires));

   // Next state.
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: if (take) state_in = ST_MUL;
         ST_MUL: begin
            if (mode_ff == MODE_MAXM || mode_ff == MODE_SUMM) state_in = ST_SQRT;
            else if (mode_ff == MODE_MINQ && yr_ff != 32'sd0) state_in = ST_DIV;
            else if (mode_ff == MODE_WSQ) state_in = ST_WSQ;
            else state_in = ST_FOLD;
         end
         ST_SQRT, ST_DIV: if (ists.done) state_in = ST_FOLD;
         ST_WSQ:  if (wcnt_ff == 2'd3) state_in = ST_FOLD;
         ST_FOLD: state_in = last_ff ? ST_OUT : ST_IDLE;
         ST_OUT:  if (out_load) state_in = ST_IDLE;
         default: state_in = ST_IDLE;
      endcase
   end

   // Iteration unit start pulses.
   always_comb begin
      ictl.start = 1'b0; ictl.op = OP_NONE;
      if (state_ff == ST_MUL && state_in == ST_SQRT) begin
         ictl.start = 1'b1; ictl.op = OP_SQRT;
      end else if (state_ff == ST_MUL && state_in == ST_DIV) begin
         ictl.start = 1'b1; ictl.op = OP_DIV;
      end
   end

   // Weighted-square product built from one 32x32 partial product per cycle.
   assign wa_half = wcnt_ff[0] ? mag2_ff[63:32] : mag2_ff[31:0];
   assign wb_half = wcnt_ff[1] ? ysq_ff[63:32] : ysq_ff[31:0];
   assign wpp = 64'(wa_half) * 64'(wb_half);
   always_comb begin
      wsh = '0;
      case (wcnt_ff)
         2'd0:       wsh = {64'd0, wpp};
         2'd1, 2'd2: wsh = {32'd0, wpp, 32'd0};
         default:    wsh = {wpp, 64'd0};
      endcase
   end

   // Product shifted right by 48 and saturated.
   assign wterm = (wacc_ff[127:111] != 17'd0) ? S64_MAX : wacc_ff[111:48];

   // Accumulator update.
   always_comb begin
      acc_re_in = acc_re_ff; acc_im_in = acc_im_ff; found_in = found_ff;
      if (state_ff == ST_FOLD) begin
         case (mode_ff)
            MODE_RDOT, MODE_CDOT: begin
               acc_re_in = sat_add(acc_re_ff, (p0_ff >>> 16) + (p1_ff >>> 16));
               if (mode_ff == MODE_CDOT)
                  acc_im_in = sat_add(acc_im_ff, (p2_ff >>> 16) - (p3_ff >>> 16));
            end
            MODE_MAXM: if ($signed(ires) > acc_re_ff) acc_re_in = ires;
            MODE_SUMM: acc_re_in = sat_add(acc_re_ff, ires);
            MODE_WSQ:  acc_re_in = sat_add(acc_re_ff, wterm);
            MODE_MINQ: if (yr_ff != 32'sd0) begin
               if (!found_ff || $signed(ires) < acc_re_ff) acc_re_in = ires;
               found_in = 1'b1;
            end
            default: ;
         endcase
      end else if (out_load) begin
         acc_re_in = '0; acc_im_in = '0; found_in = 1'b0;
      end
   end

   // Registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE; mode_ff <= MODE_RDOT;
         acc_re_ff <= '0; acc_im_ff <= '0; found_ff <= 1'b0; rsp_v_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         acc_re_ff <= acc_re_in; acc_im_ff <= acc_im_in; found_ff <= found_in;
         if (csr_valid && csr_ready) mode_ff <= csr_data;
         if (out_load) rsp_v_ff <= 1'b1;
         else if (rsp_tready) rsp_v_ff <= 1'b0;
      end
      if (take) begin
         xr_ff <= req_tdata[31:0]; xi_ff <= req_tdata[63:32];
         yr_ff <= req_tdata[95:64]; yi_ff <= req_tdata[127:96];
         last_ff <= req_tlast;
      end
      if (state_ff == ST_MUL) begin
         p0_ff <= 64'(xr_ff) * 64'(yr_ff); p1_ff <= 64'(xi_ff) * 64'(yi_ff);
         p2_ff <= 64'(xr_ff) * 64'(yi_ff); p3_ff <= 64'(xi_ff) * 64'(yr_ff);
         mag2_ff <= mag2_in;
         ysq_ff <= 64'(64'(yr_ff) * 64'(yr_ff));
         wacc_ff <= '0;
         wcnt_ff <= '0;
      end else if (state_ff == ST_WSQ) begin
         wacc_ff <= wacc_ff + wsh;
         wcnt_ff <= wcnt_ff + 2'd1;
      end
      if (out_load) begin
         rsp_u_ff <= 1'b0;
         rsp_d_ff <= '0;
         if (mode_ff <= MODE_WSQ) begin
            rsp_d_ff[63:0] <= acc_re_ff;
            if (mode_ff == MODE_CDOT) rsp_d_ff[127:64] <= acc_im_ff;
         end else if (mode_ff == MODE_MINQ) begin
            rsp_d_ff[63:0] <= found_ff ? acc_re_ff : S64_MAX;
            rsp_u_ff <= !found_ff;
         end
      end
   end

   assign rsp_tvalid = rsp_v_ff;
   assign rsp_tdata = rsp_d_ff;
   assign rsp_tuser = rsp_u_ff;

   `CVR_ASSERT_IMPL(a_no_take_busy, clock, reset, ists.busy, !req_tready)
   `CVR_ASSERT_NEXT(a_out_valid, clock, reset, state_ff == ST_OUT, rsp_tvalid)
   `CVR_ASSERT_NEXT(a_clear, clock, reset, out_load, acc_re_ff == 64'sd0 && !found_ff)
endmodule

// ===== dv/tb_complex_vector_reduction.sv =====
// Self-checking testbench for the complex vector reduction block.
`timescale 1ns / 1ps

module tb_complex_vector_reduction;
   import cvr_pkg::*;

   // Mode codes that the block treats as undefined.
   localparam logic [2:0] MODE_UNDEF6 = 3'd6;
   localparam logic [2:0] MODE_UNDEF7 = 3'd7;
   localparam logic signed [31:0] S32_MAX = 32'sh7FFF_FFFF;
   localparam logic signed [31:0] S32_MIN = 32'sh8000_0000;
   localparam int SETTLE_CYCLES = 80;

   typedef struct {
      logic signed [31:0] xr;
      logic signed [31:0] xi;
      logic signed [31:0] yr;
      logic signed [31:0] yi;
      logic               last;
   } element_type;

   typedef struct {
      logic signed [63:0] re;
      logic signed [63:0] im;
      logic               none;
   } reduction_type;

   logic         clock = 1'b0;
   logic         reset = 1'b1;
   logic         csr_valid = 1'b0;
   logic         csr_ready;
   logic [2:0]   csr_data = 3'd0;
   logic         req_tvalid = 1'b0;
   logic         req_tready;
   logic [127:0] req_tdata = '0;    // x_re, x_im, y_re, y_im
   logic         req_tlast = 1'b0;  // last_elem
   logic         rsp_tvalid;
   logic         rsp_tready = 1'b0;
   logic [127:0] rsp_tdata;         // result_re, result_im
   logic         rsp_tuser;         // none_found

   complex_vector_reduction dut (
      .clock(clock), .reset(reset),
      .csr_valid(csr_valid), .csr_ready(csr_ready), .csr_data(csr_data),
      .req_tvalid(req_tvalid), .req_tready(req_tready), .req_tdata(req_tdata),
      .req_tlast(req_tlast),
      .rsp_tvalid(rsp_tvalid), .rsp_tready(rsp_tready), .rsp_tdata(rsp_tdata),
      .rsp_tuser(rsp_tuser)
   );

   element_type   element_queue[$];
   reduction_type reduction_queue[$];

   // Predictor state.
   logic [2:0]         cur_mode = MODE_RDOT;
   logic signed [63:0] sum_real = 0;
   logic signed [63:0] sum_imag = 0;
   logic               quot_seen = 1'b0;

   int  error_count = 0;
   bit  hold_sender = 1'b0;
   bit  stall_request = 1'b0;

   initial begin
      forever #5 clock = ~clock;
   end

   initial begin
      #10ms;
      $display("DONE: errors detected");
      $finish;
   end

   function automatic logic signed [63:0] add_sat64(logic signed [63:0] a,
                                                    logic signed [63:0] b);
      logic signed [64:0] s;
      s = 65'(a) + 65'(b);
      if (s > 65'(S64_MAX)) return S64_MAX;
      if (s < 65'(S64_MIN)) return S64_MIN;
      return s[63:0];
   endfunction

   function automatic logic [63:0] root64(logic [63:0] v);
      logic [63:0] r;
      logic [63:0] b;
      r = 0;
      b = 64'd1 << 62;
      while (b > v) b = b >> 2;
      while (b != 0) begin
         if (v >= r + b) begin
            v = v - (r + b);
            r = (r >> 1) + b;
         end else begin
            r = r >> 1;
         end
         b = b >> 2;
      end
      return r;
   endfunction

   // Fold one accepted element into the predicted accumulators.
   task automatic fold_element(element_type e);
      logic signed [63:0] xr, xi, yr, yi, t_re, t_im, q, m;
      logic [63:0]        mag2;
      logic [127:0]       wide;
      reduction_type      res;
      xr = e.xr; xi = e.xi; yr = e.yr; yi = e.yi;
      mag2 = 64'(xr * xr) + 64'(xi * xi);
      case (cur_mode)
         MODE_RDOT, MODE_CDOT: begin
            t_re = ((xr * yr) >>> 16) + ((xi * yi) >>> 16);
            sum_real = add_sat64(sum_real, t_re);
            if (cur_mode == MODE_CDOT) begin
               t_im = ((xr * yi) >>> 16) - ((xi * yr) >>> 16);
               sum_imag = add_sat64(sum_imag, t_im);
            end
         end
         MODE_MAXM: begin
            m = root64(mag2);
            if (m > sum_real) sum_real = m;
         end
         MODE_SUMM: sum_real = add_sat64(sum_real, root64(mag2));
         MODE_WSQ: begin
            wide = 128'(mag2) * 128'(64'(yr * yr));
            if (wide[127:111] != 0) m = S64_MAX;
            else m = wide[111:48];
            sum_real = add_sat64(sum_real, m);
         end
         MODE_MINQ: begin
            if (yr != 0) begin
               q = (xr * 64'sd65536) / yr;
               if (!quot_seen || q < sum_real) sum_real = q;
               quot_seen = 1'b1;
            end
         end
         default: ;
      endcase
      if (e.last) begin
         res.re = 0; res.im = 0; res.none = 1'b0;
         if (cur_mode <= MODE_WSQ) begin
            res.re = sum_real;
            if (cur_mode == MODE_CDOT) res.im = sum_imag;
         end else if (cur_mode == MODE_MINQ) begin
            if (quot_seen) res.re = sum_real;
            else begin
               res.re = S64_MAX;
               res.none = 1'b1;
            end
         end
         reduction_queue.push_back(res);
         sum_real = 0;
         sum_imag = 0;
         quot_seen = 1'b0;
      end
   endtask

   // Request driver: bursts of random length separated by random gaps.
   int burst_left = 0;
   int gap_left = 0;
   always @(posedge clock) begin
      if (reset) begin
         req_tvalid <= 1'b0;
         burst_left = 4;
         gap_left = 0;
      end else begin
         if (req_tvalid && req_tready) begin
            fold_element(element_queue[0]);
            void'(element_queue.pop_front());
            burst_left--;
            if (burst_left <= 0) begin
               burst_left = $urandom_range(1, 16);
               gap_left = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 12);
            end
         end
         if (!req_tvalid || (req_tvalid && req_tready)) begin
            if (gap_left > 0) begin
               gap_left--;
               req_tvalid <= 1'b0;
            end else if (hold_sender || element_queue.size() == 0) begin
               req_tvalid <= 1'b0;
            end else begin
               req_tvalid <= 1'b1;
               req_tdata <= {element_queue[0].yi, element_queue[0].yr,
                             element_queue[0].xi, element_queue[0].xr};
               req_tlast <= element_queue[0].last;
            end
         end
      end
   end

   // Response ready pattern, with one long hold-off on request.
   int  hold_left = 0;
   int  pattern_cycle = 0;
   bit  stall_served = 1'b0;
   always @(posedge clock) begin
      if (reset) begin
         rsp_tready <= 1'b0;
      end else if (hold_left > 0) begin
         hold_left--;
         rsp_tready <= 1'b0;
      end else if (stall_request && !stall_served) begin
         stall_served = 1'b1;
         hold_left = 600;
         rsp_tready <= 1'b0;
      end else begin
         pattern_cycle++;
         case ((pattern_cycle / 97) % 4)
            0: rsp_tready <= 1'b1;
            1: rsp_tready <= ($urandom_range(0, 1) == 1);
            2: rsp_tready <= ($urandom_range(0, 9) != 0);
            default: rsp_tready <= (pattern_cycle % 3 == 0);
         endcase
      end
   end

   // Response monitor: compare each transaction with the oldest prediction.
   always @(posedge clock) begin
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (reduction_queue.size() == 0) begin
            $error("response with no prediction pending");
            error_count++;
         end else begin
            if (rsp_tdata[63:0] !== reduction_queue[0].re) begin
               $error("result_re expected %0d actual %0d",
                      reduction_queue[0].re, $signed(rsp_tdata[63:0]));
               error_count++;
            end
            if (rsp_tdata[127:64] !== reduction_queue[0].im) begin
               $error("result_im expected %0d actual %0d",
                      reduction_queue[0].im, $signed(rsp_tdata[127:64]));
               error_count++;
            end
            if (rsp_tuser !== reduction_queue[0].none) begin
               $error("none_found expected %0b actual %0b",
                      reduction_queue[0].none, rsp_tuser);
               error_count++;
            end
            void'(reduction_queue.pop_front());
         end
      end
   end

   task automatic push_element(logic signed [31:0] xr, logic signed [31:0] xi,
                               logic signed [31:0] yr, logic signed [31:0] yi,
                               logic last);
      element_type e;
      e.xr = xr; e.xi = xi; e.yr = yr; e.yi = yi; e.last = last;
      element_queue.push_back(e);
   endtask

   // Wait until the block has drained, then let it settle.
   task automatic wait_drained();
      while (element_queue.size() != 0 || req_tvalid || reduction_queue.size() != 0)
         @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_mode(logic [2:0] m);
      wait_drained();
      csr_valid <= 1'b1;
      csr_data <= m;
      do @(posedge clock); while (!csr_ready);
      cur_mode = m;
      csr_valid <= 1'b0;
   endtask

   function automatic logic signed [31:0] pick_value();
      case ($urandom_range(0, 9))
         0: return S32_MAX;
         1: return S32_MIN;
         2: return 0;
         3, 4: return $signed($urandom_range(0, 1 << 20)) - (1 << 19);
         default: return $urandom;
      endcase
   endfunction

   initial begin
      int len;
      int phase;
      logic [2:0] m;
      logic signed [31:0] den;
      repeat (4) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Directed part: extremes and special cases per mode.
      write_mode(MODE_RDOT);
      push_element(S32_MAX, S32_MAX, S32_MAX, S32_MAX, 1'b0);
      push_element(S32_MIN, S32_MIN, S32_MIN, S32_MIN, 1'b0);
      push_element(S32_MIN, S32_MAX, S32_MAX, S32_MIN, 1'b1);
      write_mode(MODE_CDOT);
      push_element(S32_MIN, S32_MIN, S32_MIN, S32_MAX, 1'b0);
      push_element(12345, -1, -7, 3, 1'b1);
      // Maximum modulus starts from zero.
      write_mode(MODE_MAXM);
      push_element(0, 0, S32_MIN, S32_MAX, 1'b1);
      push_element(S32_MIN, S32_MIN, 0, 0, 1'b0);
      push_element(3, 4, 0, 0, 1'b1);
      write_mode(MODE_SUMM);
      push_element(S32_MAX, S32_MIN, 0, 0, 1'b0);
      push_element(1, 1, 0, 0, 1'b1);
      // Weighted squares at the largest magnitudes saturate.
      write_mode(MODE_WSQ);
      push_element(S32_MIN, S32_MIN, S32_MIN, 0, 1'b0);
      push_element(S32_MIN, S32_MIN, S32_MIN, 0, 1'b1);
      push_element(65536, 0, -65536, 0, 1'b1);
      // No usable denominator, then mixed zero and nonzero denominators.
      write_mode(MODE_MINQ);
      push_element(5, 0, 0, 0, 1'b1);
      push_element(S32_MIN, 0, -1, 0, 1'b0);
      push_element(-7, 0, 0, 0, 1'b0);
      push_element(S32_MAX, 0, 1, 0, 1'b1);
      // Mode change within a vector keeps the accumulators.
      write_mode(MODE_RDOT);
      push_element(65536, 0, 65536, 0, 1'b0);
      write_mode(MODE_SUMM);
      push_element(0, 65536, 0, 0, 1'b1);
      write_mode(MODE_UNDEF6);
      push_element(1, 2, 3, 4, 1'b0);
      push_element(5, 6, 7, 8, 1'b1);
      write_mode(MODE_UNDEF7);
      push_element(1, 1, 1, 1, 1'b1);

      // Random part: short vectors under a sequence of modes.
      for (phase = 0; phase < 12; phase++) begin
         if (phase < 8) m = 3'(phase);
         else m = $urandom_range(0, 7);
         write_mode(m);
         for (int n = 0; n < 60; n += len) begin
            len = ($urandom_range(0, 7) == 0) ? $urandom_range(7, 12)
                                               : $urandom_range(1, 5);
            for (int k = 0; k < len; k++) begin
               den = pick_value();
               if (m == MODE_MINQ && $urandom_range(0, 3) == 0) den = 0;
               push_element(pick_value(), pick_value(), den, pick_value(),
                            k == len - 1);
            end
            if (phase == 3 && n == 0) stall_request = 1'b1;
            if (phase == 6 && n >= 30 && !hold_sender) begin
               // Sender pauses until every pending result has arrived.
               hold_sender = 1'b1;
               while (req_tvalid || reduction_queue.size() != 0) @(posedge clock);
               hold_sender = 1'b0;
            end
         end
      end

      wait_drained();
      if (error_count == 0) begin
         $display("DONE: 0 errors");
      end else begin
         $display("DONE: errors detected");
      end
      $finish;
   end
endmodule

// ===== filelist.f =====
+incdir+design
design/cvr_pkg.sv
design/cvr_iter.sv
design/complex_vector_reduction.sv
dv/tb_complex_vector_reduction.sv
